>>> rtl/ihex_pkg.sv
package ihex_pkg;

  localparam int COUNT_WIDTH = 20;
  localparam int TOTAL_W     = 20;
  localparam int POS_W       = 10;
  localparam int IDX_W       = 7;
  localparam int LEN_W       = POS_W + 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [POS_W-1:0]       POS_MAX   = {POS_W{1'b1}};

  localparam logic [POS_W-1:0] POS_COUNT_HI = POS_W'(1);
  localparam logic [POS_W-1:0] POS_COUNT_LO = POS_W'(2);
  localparam logic [POS_W-1:0] POS_ADDR_HI  = POS_W'(3);
  localparam logic [POS_W-1:0] POS_ADDR_LO  = POS_W'(6);
  localparam logic [POS_W-1:0] POS_TYPE     = POS_W'(8);
  localparam logic [POS_W-1:0] POS_DATA     = POS_W'(9);
  localparam logic [LEN_W-1:0] MIN_LINE_LEN = LEN_W'(11);

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_DONE   = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [15:0]          data_word;
    logic [15:0]          word_address;
    logic [TOTAL_W-1:0]   total_words;
    logic                 final_result;
  } result_t;

  // results produced by one accepted character, in delivery order
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  // bit 4 set means not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h37);
    return v;
  endfunction

endpackage

>>> rtl/ihex_line_parser.sv
module ihex_line_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [7:0]           text_char,
  input  logic                 end_of_file,
  input  logic                 cfg_wen,
  input  logic                 cfg_wdata,
  output ihex_pkg::push_t      push
);

  logic                            little_endian;
  logic [ihex_pkg::POS_W-1:0]      char_position, char_position_next;
  logic [7:0]                      record_byte_count, record_byte_count_next;
  logic [15:0]                     record_start_address, record_start_address_next;
  logic                            is_data_record, is_data_record_next;
  logic                            colon_seen, colon_seen_next;
  logic [ihex_pkg::IDX_W-1:0]      word_index, word_index_next;
  logic [15:0]                     digit_shift, digit_shift_next;
  logic                            error_seen, error_seen_next;
  logic [ihex_pkg::COUNT_WIDTH-1:0] word_total, word_total_next;
  logic                            text_cut, text_cut_next;

  logic                            newline;
  logic [4:0]                      hv;
  logic [3:0]                      digit;
  logic [1:0]                      group_pos;
  logic                            emit;
  logic [15:0]                     word;
  logic [15:0]                     word_addr;
  logic [ihex_pkg::LEN_W-1:0]      line_len;
  ihex_pkg::result_t               data_res, status_res;

  always_comb begin
    char_position_next        = char_position;
    record_byte_count_next    = record_byte_count;
    record_start_address_next = record_start_address;
    is_data_record_next       = is_data_record;
    colon_seen_next           = colon_seen;
    word_index_next           = word_index;
    digit_shift_next          = digit_shift;
    error_seen_next           = error_seen;
    word_total_next           = word_total;
    text_cut_next             = text_cut;
    emit                      = 1'b0;
    word                      = '0;
    line_len                  = '0;

    newline   = (text_char == ihex_pkg::CHAR_NL);
    hv        = ihex_pkg::hex_value(text_char);
    digit     = hv[4] ? 4'h0 : hv[3:0];
    // digit slot inside a four-digit group, counted from position 9
    group_pos = 2'(char_position - ihex_pkg::POS_W'(1));
    word_addr = {1'b0, record_start_address[15:1]} + 16'(word_index);

    if (!text_cut && !newline) begin
      if (text_char == ihex_pkg::CHAR_NUL) begin
        text_cut_next = 1'b1;
      end else begin
        if (text_char == ihex_pkg::CHAR_COLON) colon_seen_next = 1'b1;
        if (char_position >= ihex_pkg::POS_COUNT_HI &&
            char_position <= ihex_pkg::POS_ADDR_LO) begin
          if (hv[4]) error_seen_next = 1'b1;
          if (char_position == ihex_pkg::POS_COUNT_HI ||
              char_position == ihex_pkg::POS_ADDR_HI)
            digit_shift_next = {12'h000, digit};
          else
            digit_shift_next = {digit_shift[11:0], digit};
          if (char_position == ihex_pkg::POS_COUNT_LO)
            record_byte_count_next = digit_shift_next[7:0];
          if (char_position == ihex_pkg::POS_ADDR_LO)
            record_start_address_next = digit_shift_next;
        end else if (char_position == ihex_pkg::POS_TYPE) begin
          is_data_record_next = (text_char == ihex_pkg::CHAR_ZERO);
        end else if (char_position >= ihex_pkg::POS_DATA && is_data_record &&
                     word_index < record_byte_count[7:1]) begin
          if (hv[4]) error_seen_next = 1'b1;
          if (group_pos == 2'd0) digit_shift_next = {12'h000, digit};
          else digit_shift_next = {digit_shift[11:0], digit};
          if (group_pos == 2'd3) begin
            word = little_endian ? {digit_shift_next[7:0], digit_shift_next[15:8]}
                                 : digit_shift_next;
            if (!error_seen_next) begin
              emit = 1'b1;
              if (word_total != ihex_pkg::COUNT_MAX)
                word_total_next = word_total + 1'b1;
            end
            word_index_next = word_index + 1'b1;
          end
        end
        if (char_position != ihex_pkg::POS_MAX)
          char_position_next = char_position + 1'b1;
      end
    end

    if (newline || end_of_file) begin
      line_len = ihex_pkg::LEN_W'(char_position_next);
      if (newline && !text_cut) line_len = line_len + 1'b1;
      if (line_len < ihex_pkg::MIN_LINE_LEN) error_seen_next = 1'b1;
      if (!colon_seen_next) error_seen_next = 1'b1;
      if (is_data_record_next && word_index_next < record_byte_count_next[7:1])
        error_seen_next = 1'b1;
      char_position_next        = '0;
      record_byte_count_next    = '0;
      record_start_address_next = '0;
      is_data_record_next       = 1'b0;
      colon_seen_next           = 1'b0;
      word_index_next           = '0;
      digit_shift_next          = '0;
      text_cut_next             = 1'b0;
    end
  end

  always_comb begin
    data_res.kind         = ihex_pkg::KIND_DATA;
    data_res.data_word    = word;
    data_res.word_address = word_addr;
    data_res.total_words  = ihex_pkg::TOTAL_W'(word_total_next);
    data_res.final_result = !end_of_file;

    status_res.data_word    = '0;
    status_res.word_address = '0;
    status_res.final_result = 1'b1;
    if (error_seen_next || word_total_next == '0) begin
      status_res.kind        = ihex_pkg::KIND_REJECT;
      status_res.total_words = '0;
    end else begin
      status_res.kind        = ihex_pkg::KIND_DONE;
      status_res.total_words = ihex_pkg::TOTAL_W'(word_total_next);
    end

    push.count  = accept ? (2'(emit) + 2'(end_of_file)) : 2'd0;
    push.first  = emit ? data_res : status_res;
    push.second = status_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      little_endian        <= 1'b1;
      char_position        <= '0;
      record_byte_count    <= '0;
      record_start_address <= '0;
      is_data_record       <= 1'b0;
      colon_seen           <= 1'b0;
      word_index           <= '0;
      digit_shift          <= '0;
      error_seen           <= 1'b0;
      word_total           <= '0;
      text_cut             <= 1'b0;
    end else begin
      if (cfg_wen) little_endian <= cfg_wdata;
      if (accept) begin
        char_position        <= char_position_next;
        record_byte_count    <= record_byte_count_next;
        record_start_address <= record_start_address_next;
        is_data_record       <= is_data_record_next;
        colon_seen           <= colon_seen_next;
        word_index           <= word_index_next;
        digit_shift          <= digit_shift_next;
        error_seen           <= error_seen_next;
        word_total           <= word_total_next;
        text_cut             <= text_cut_next;
      end
    end
  end

endmodule

>>> rtl/ihex_result_queue.sv
module ihex_result_queue (
  input  logic              clk,
  input  logic              rst,
  input  ihex_pkg::push_t   push,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output ihex_pkg::result_t out_result
);

  ihex_pkg::result_t              entries [ihex_pkg::QUEUE_DEPTH];
  logic [ihex_pkg::QPTR_W-1:0]    wr_ptr, rd_ptr;
  logic [ihex_pkg::QCNT_W-1:0]    count;
  logic                           pop;

  assign out_valid  = (count != '0);
  assign out_result = entries[rd_ptr];
  assign pop        = out_valid && out_ready;
  // a character can bring two results, so keep two entries free
  assign room       = (count <= ihex_pkg::QCNT_W'(ihex_pkg::QUEUE_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) entries[wr_ptr] <= push.first;
    if (push.count == 2'd2) entries[wr_ptr + 1'b1] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + ihex_pkg::QPTR_W'(push.count);
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + ihex_pkg::QCNT_W'(push.count) - ihex_pkg::QCNT_W'(pop);
    end
  end

endmodule

>>> rtl/ihex_word_stream_parser.sv
// results are registered in the result queue and presented on the master side from it
// throughput: one character per cycle while s_tready is high; a character yields zero, one or two results
// the four-entry result queue holds s_tready low while fewer than two entries are free
// reset (synchronous, rst high) clears line state, error flag, word total and queue,
// and sets little_endian to 1
module ihex_word_stream_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] text_char
  input  logic        s_tlast,   // end_of_file
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [15:0] data_word, [31:16] word_address, [51:32] total_words
  output logic [1:0]  m_tuser,   // [1:0] result_kind
  output logic        m_tlast,   // final_result
  input  logic        cfg_wen,
  input  logic        cfg_wdata  // little_endian
);

  ihex_pkg::push_t   push;
  ihex_pkg::result_t res;
  logic              accept;

  assign accept = s_tvalid && s_tready;

  ihex_line_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .text_char   (s_tdata),
    .end_of_file (s_tlast),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata),
    .push        (push)
  );

  ihex_result_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .room       (s_tready),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (res)
  );

  assign m_tdata = {4'h0, res.total_words, res.word_address, res.data_word};
  assign m_tuser = res.kind;
  assign m_tlast = res.final_result;

endmodule

>>> rtl/ihex_checker.sv
module ihex_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  // queue is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result dropped or changed");

  // a file status always closes the results of its character
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ihex_pkg::KIND_DATA |-> m_tlast)
    else $error("status result without tlast");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ihex_pkg::KIND_REJECT |-> m_tdata == '0)
    else $error("rejected status carries data");

endmodule

bind ihex_word_stream_parser ihex_checker u_checker (.*);

>>> sim/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_wen = 1'b0;
  logic        cfg_wdata = 1'b0;

  ihex_word_stream_parser i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // parser state as the block should hold it
  logic                         swap_bytes = 1'b1;
  int                           line_pos = 0;
  logic [7:0]                   line_count = '0;
  logic [15:0]                  line_addr = '0;
  logic                         line_is_data = 1'b0;
  logic                         line_has_colon = 1'b0;
  logic [6:0]                   line_word = '0;
  logic [15:0]                  digits = '0;
  logic                         line_cut = 1'b0;
  logic                         file_error = 1'b0;
  logic [ihex_pkg::TOTAL_W-1:0] word_count = '0;

  ihex_pkg::result_t results_due[$];
  logic [7:0]        line_q[$];
  int                chars_sent = 0;
  int                burst_left = 1;
  int                mismatches = 0;
  int                cycle_count = 0;
  logic [15:0]       stall_tick = '0;
  logic [1:0]        stall_mode = '0;
  logic              got_fire = 1'b0;
  ihex_pkg::result_t got;
  ihex_pkg::result_t want;

  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
    if (c >= "a" && c <= "f") return {1'b0, 4'(c - "a" + 8'd10)};
    if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 8'd10)};
    return 5'h10;
  endfunction

  function automatic ihex_pkg::result_t make_result(input ihex_pkg::kind_t k,
                                                    input logic [15:0] w,
                                                    input logic [15:0] a,
                                                    input logic [ihex_pkg::TOTAL_W-1:0] t);
    ihex_pkg::result_t r;
    r.kind         = k;
    r.data_word    = w;
    r.word_address = a;
    r.total_words  = t;
    r.final_result = 1'b0;
    return r;
  endfunction

  function automatic void clear_line();
    line_pos       = 0;
    line_count     = '0;
    line_addr      = '0;
    line_is_data   = 1'b0;
    line_has_colon = 1'b0;
    line_word      = '0;
    digits         = '0;
    line_cut       = 1'b0;
  endfunction

  // advance the parser by one character and queue what it should emit
  function automatic void parse_char(input logic [7:0] c, input logic eof);
    ihex_pkg::result_t found[2];
    int                n;
    int                grp;
    int                len;
    logic [4:0]        nib;
    logic [15:0]       w;
    n = 0;
    if (!line_cut && c != ihex_pkg::CHAR_NL) begin
      if (c == ihex_pkg::CHAR_NUL) begin
        line_cut = 1'b1;
      end else begin
        nib = nibble_of(c);
        if (c == ihex_pkg::CHAR_COLON) line_has_colon = 1'b1;
        if (line_pos >= ihex_pkg::POS_COUNT_HI && line_pos <= ihex_pkg::POS_ADDR_LO) begin
          if (nib[4]) begin
            file_error = 1'b1;
            nib = 5'd0;
          end
          if (line_pos == ihex_pkg::POS_COUNT_HI || line_pos == ihex_pkg::POS_ADDR_HI)
            digits = {12'h000, nib[3:0]};
          else digits = {digits[11:0], nib[3:0]};
          if (line_pos == ihex_pkg::POS_COUNT_LO) line_count = digits[7:0];
          if (line_pos == ihex_pkg::POS_ADDR_LO) line_addr = digits;
        end else if (line_pos == ihex_pkg::POS_TYPE) begin
          line_is_data = (c == ihex_pkg::CHAR_ZERO);
        end else if (line_pos >= ihex_pkg::POS_DATA && line_is_data &&
                     line_word < line_count[7:1]) begin
          grp = (line_pos - ihex_pkg::POS_DATA) & 3;
          if (nib[4]) begin
            file_error = 1'b1;
            nib = 5'd0;
          end
          if (grp == 0) digits = {12'h000, nib[3:0]};
          else digits = {digits[11:0], nib[3:0]};
          if (grp == 3) begin
            w = swap_bytes ? {digits[7:0], digits[15:8]} : digits;
            if (!file_error) begin
              if (word_count != ihex_pkg::COUNT_MAX) word_count++;
              found[n] = make_result(ihex_pkg::KIND_DATA, w,
                                     (line_addr >> 1) + 16'(line_word), word_count);
              n++;
            end
            line_word++;
          end
        end
        if (line_pos < ihex_pkg::POS_MAX) line_pos++;
      end
    end
    if (c == ihex_pkg::CHAR_NL || eof) begin
      len = (c == ihex_pkg::CHAR_NL && !line_cut) ? line_pos + 1 : line_pos;
      if (len < ihex_pkg::MIN_LINE_LEN || !line_has_colon ||
          (line_is_data && line_word < line_count[7:1]))
        file_error = 1'b1;
      clear_line();
    end
    if (eof) begin
      if (file_error || word_count == 0)
        found[n] = make_result(ihex_pkg::KIND_REJECT, '0, '0, '0);
      else found[n] = make_result(ihex_pkg::KIND_DONE, '0, '0, word_count);
      n++;
    end
    for (int k = 0; k < n; k++) begin
      if (k == n - 1) found[k].final_result = 1'b1;
      results_due.push_back(found[k]);
    end
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return ($urandom_range(0, 1) ? "a" : "A") + 8'(v) - 8'd10;
  endfunction

  // any byte except NUL and newline
  function automatic logic [7:0] junk_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == ihex_pkg::CHAR_NL);
    return c;
  endfunction

  function automatic void push_hex(input logic [15:0] v, input int nd);
    for (int i = nd - 1; i >= 0; i--) line_q.push_back(hex_char(4'(v >> (4 * i))));
  endfunction

  function automatic void build_record(input int bc, input logic [15:0] addr,
                                       input bit data_rec, input int junk_n);
    logic [7:0] c;
    line_q.delete();
    line_q.push_back(ihex_pkg::CHAR_COLON);
    push_hex(16'(bc), 2);
    push_hex(addr, 4);
    line_q.push_back(($urandom_range(0, 3) == 0) ? junk_byte() : ihex_pkg::CHAR_ZERO);
    if (data_rec) begin
      line_q.push_back(ihex_pkg::CHAR_ZERO);
      repeat (bc >> 1) push_hex(16'($urandom), 4);
      if (bc % 2) push_hex(16'($urandom), 2);
    end else begin
      do c = junk_byte(); while (c == ihex_pkg::CHAR_ZERO);
      line_q.push_back(c);
      push_hex(16'($urandom), 2 * $urandom_range(0, 4));
    end
    push_hex(16'($urandom), 2);
    repeat (junk_n) line_q.push_back(junk_byte());
  endfunction

  task automatic send_char(input logic [7:0] c, input logic eof);
    logic ready_seen;
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= eof;
    // outputs settle well before the falling edge, sample there
    do begin
      @(negedge clk);
      ready_seen = s_tready;
      @(posedge clk);
    end while (!ready_seen);
    parse_char(c, eof);
    chars_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  task automatic send_text(input string s, input bit eof_end);
    for (int i = 0; i < s.len(); i++) send_char(s[i], eof_end && i == s.len() - 1);
  endtask

  // eof may land on the newline or on the last text character
  task automatic send_line(input bit eof_end);
    if (!eof_end || $urandom_range(0, 1)) line_q.push_back(ihex_pkg::CHAR_NL);
    for (int i = 0; i < line_q.size(); i++)
      send_char(line_q[i], eof_end && i == line_q.size() - 1);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_little_endian(input logic v);
    drain();
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen    <= 1'b0;
    swap_bytes = v;
  endtask

  task automatic test_empty_file();
    send_text(":00000000FF\n", 0);
    send_text(":00000001FF\n", 1);
  endtask

  task automatic test_field_extremes();
    send_text(":03123400A1B2C3FF\n", 0);
    send_text(":0AFFFE00FFFF0000aBcD1234fFfF5A", 1);
  endtask

  task automatic test_text_order();
    set_little_endian(1'b0);
    send_text(":04000000DEADbeef00\n", 0);
    send_text(":00000001FF\n", 1);
    set_little_endian(1'b1);
  endtask

  task automatic test_nul_cut();
    send_text(":0212340056789A", 0);
    send_char(ihex_pkg::CHAR_NUL, 0);
    send_char(8'hFF, 0);
    send_char(8'h80, 0);
    send_char(ihex_pkg::CHAR_NUL, 0);
    send_char(ihex_pkg::CHAR_NL, 1);
  endtask

  // full byte count and top address, the word index runs to its top value
  task automatic test_long_line();
    build_record(255, 16'hFFFF, 1, 0);
    send_line(1);
  endtask

  task automatic test_random_records();
    int stop_at;
    int bc;
    stop_at = chars_sent + 100;
    while (chars_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) set_little_endian(1'($urandom_range(0, 1)));
      bc = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(0, 16);
      build_record(bc, 16'($urandom), $urandom_range(0, 7) != 0,
                   ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0);
      if ($urandom_range(0, 7) == 0) begin
        line_q.push_back(ihex_pkg::CHAR_NUL);
        repeat ($urandom_range(0, 3)) line_q.push_back(junk_byte());
      end
      send_line($urandom_range(0, 7) == 0);
    end
    build_record(4, 16'($urandom), 1, 0);
    send_line(1);
  endtask

  // the error flag never clears, so these run after all clean traffic
  task automatic test_error_cases();
    send_text(":0400\n", 0);
    send_text("0400000111223344CC\n", 0);
    send_text(":0G00000011\n", 0);
    send_text(":0800000011223344\n", 0);
    build_record(4, 16'($urandom), 1, 0);
    send_line(1);
  endtask

  task automatic test_noise();
    repeat (60)
      send_char(($urandom_range(0, 5) == 0) ? ihex_pkg::CHAR_NL : 8'($urandom_range(0, 255)),
                $urandom_range(0, 39) == 0);
    send_char(ihex_pkg::CHAR_NL, 1);
  endtask

  // receiver back-pressure, mode changes each time stall_tick[5:0] returns to zero
  always @(posedge clk) begin
    stall_tick <= stall_tick + 16'd1;
    if (stall_tick[5:0] == 6'd0) stall_mode <= 2'($urandom_range(0, 3));
    case (stall_mode)
      2'd0: m_tready <= 1'b1;
      2'd1: m_tready <= 1'($urandom_range(0, 1));
      2'd2: m_tready <= (stall_tick[1:0] == 2'd0);
      default: m_tready <= (stall_tick[4:0] < 5'd3);
    endcase
  end

  always @(negedge clk) begin
    got_fire          = m_tvalid && m_tready && !rst;
    got.kind          = ihex_pkg::kind_t'(m_tuser);
    got.data_word     = m_tdata[15:0];
    got.word_address  = m_tdata[31:16];
    got.total_words   = m_tdata[51:32];
    got.final_result  = m_tlast;
  end

  always @(posedge clk) begin
    if (got_fire) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected transaction, kind %0d word %h", $time, got.kind,
                 got.data_word);
        mismatches++;
      end else begin
        want = results_due.pop_front();
        if (got.kind != want.kind) begin
          $display("%0t: result_kind expected %0d actual %0d", $time, want.kind, got.kind);
          mismatches++;
        end
        if (got.data_word != want.data_word) begin
          $display("%0t: data_word expected %h actual %h", $time, want.data_word,
                   got.data_word);
          mismatches++;
        end
        if (got.word_address != want.word_address) begin
          $display("%0t: word_address expected %h actual %h", $time, want.word_address,
                   got.word_address);
          mismatches++;
        end
        if (got.total_words != want.total_words) begin
          $display("%0t: total_words expected %0d actual %0d", $time, want.total_words,
                   got.total_words);
          mismatches++;
        end
        if (got.final_result != want.final_result) begin
          $display("%0t: final_result expected %0d actual %0d", $time, want.final_result,
                   got.final_result);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_empty_file();
    test_field_extremes();
    test_text_order();
    test_nul_cut();
    test_long_line();
    test_random_records();
    test_error_cases();
    test_noise();
    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
